// ===== src/phase_accumulator_sync_pm_top_macros.svh =====
// assertion macros used by the port checker
`ifndef PHASE_ACCUMULATOR_SYNC_PM_TOP_MACROS_SVH
`define PHASE_ACCUMULATOR_SYNC_PM_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PASP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PASP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pasp_pkg.sv =====
// ----------------------------------------------------------------------------
// pasp_pkg
// types and constants of the phase accumulator with hard sync and phase mod
// ----------------------------------------------------------------------------
package pasp_pkg;

	localparam int FRAC_BITS = 24;
	localparam int ACC_BITS  = FRAC_BITS + 1;
	localparam int PROD_BITS = 2 * FRAC_BITS;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [FRAC_BITS-1:0] phase_inc;
		logic                 sync_valid;
		logic [FRAC_BITS-1:0] sync_frac;
		logic [FRAC_BITS-1:0] phase_shift;
	} in_item_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] phase_out;
		logic                 sync_out_valid;
		logic [ACC_BITS-1:0]  sync_out_frac;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul;
		logic calc;
		logic div_step;
		logic div_first;
		logic out_load;
	} cmd_t;

endpackage

// ===== src/pasp_dp.sv =====
// ----------------------------------------------------------------------------
// pasp_dp
// datapath: input capture, sync multiply, wrap and advance, radix-2 divider
// ----------------------------------------------------------------------------
module pasp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pasp_pkg::cmd_t     cmd,
	input  pasp_pkg::in_item_t in_data,
	output pasp_pkg::out_item_t out_data
);

	logic [pasp_pkg::FRAC_BITS-1:0] inc_q;
	logic                           sync_q;
	logic [pasp_pkg::FRAC_BITS-1:0] spos_q;
	logic [pasp_pkg::FRAC_BITS-1:0] shift_q;
	logic [pasp_pkg::PROD_BITS-1:0] prod_q;
	logic [pasp_pkg::ACC_BITS-1:0]  acc_q;
	logic [pasp_pkg::FRAC_BITS-1:0] phase_q;
	logic                           wrap_q;
	logic                           div_en_q;
	logic [pasp_pkg::ACC_BITS-1:0]  rem_q;
	logic [pasp_pkg::ACC_BITS-1:0]  quo_q;
	pasp_pkg::out_item_t            out_q;

	logic [pasp_pkg::FRAC_BITS-1:0] ph;
	logic                           wrap;
	logic                           div_en;
	logic [pasp_pkg::ACC_BITS-1:0]  trial;
	logic                           fits;

	// a synced phase is below one cycle, so only the running phase can wrap
	assign ph   = sync_q ? prod_q[pasp_pkg::PROD_BITS-1:pasp_pkg::FRAC_BITS]
	                     : acc_q[pasp_pkg::FRAC_BITS-1:0];
	assign wrap = !sync_q && acc_q[pasp_pkg::FRAC_BITS];
	assign div_en = wrap && (inc_q != '0) && (ph < inc_q);

	// first step compares the numerator itself, later steps shift left
	assign trial = cmd.div_first ? rem_q : {rem_q[pasp_pkg::ACC_BITS-2:0], 1'b0};
	assign fits  = trial >= {1'b0, inc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.calc) begin
			acc_q <= {1'b0, ph} + {1'b0, inc_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inc_q   <= in_data.phase_inc;
			sync_q  <= in_data.sync_valid;
			spos_q  <= in_data.sync_frac;
			shift_q <= in_data.phase_shift;
		end
		if (cmd.mul) begin
			prod_q <= inc_q * spos_q;
		end
		if (cmd.calc) begin
			phase_q  <= ph + shift_q;
			wrap_q   <= wrap;
			div_en_q <= div_en;
			rem_q    <= {1'b0, inc_q - ph};
			quo_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= fits ? (trial - {1'b0, inc_q}) : trial;
			quo_q <= {quo_q[pasp_pkg::ACC_BITS-2:0], fits};
		end
		if (cmd.out_load) begin
			out_q.phase_out      <= phase_q;
			out_q.sync_out_valid <= wrap_q;
			out_q.sync_out_frac  <= div_en_q ? quo_q : '0;
		end
	end

	assign out_data = out_q;

endmodule

// ===== src/pasp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pasp_ctrl
// sequencer: accept, multiply, update phase, divide, hand off to output reg
// ----------------------------------------------------------------------------
module pasp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output pasp_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [pasp_pkg::CNT_BITS-1:0] cnt_q;
	logic                          out_valid_q;
	logic                          out_free;
	logic                          last_step;

	assign out_free  = !out_valid_q || !out_stall;
	assign last_step = cnt_q == pasp_pkg::CNT_BITS'(pasp_pkg::DIV_STEPS - 1);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.mul       = state_q == ST_MUL;
		cmd.calc      = state_q == ST_CALC;
		cmd.div_step  = state_q == ST_DIV;
		cmd.div_first = (state_q == ST_DIV) && (cnt_q == '0);
		cmd.out_load  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a stalled beat stays, a handed-off result raises a new one
			out_valid_q <= (out_valid_q && out_stall) || ((state_q == ST_DONE) && out_free);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// wait until the output register can take the beat
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== src/phase_accumulator_sync_pm_top.sv =====
// ----------------------------------------------------------------------------
// phase_accumulator_sync_pm_top
// Phase accumulator with hard sync, wrap pulse and phase modulation output.
// ----------------------------------------------------------------------------
// Input channel in_valid / in_stall carries one beat per audio sample:
// increment, sync request with its position, and modulation offset.
// Output channel out_valid / out_stall carries one beat per input beat:
// modulated phase, wrap pulse and the intersample wrap position.
// A beat is taken at a clock edge where valid is high and stall is low.
// Each beat is captured, then passes the sync multiply, the phase update,
// the 25-step radix-2 divider for the wrap position and the load of the
// output register before the controller returns to idle; in_stall is high
// and no new beat is taken until it is back in idle.
// The output register frees the controller: while a result waits under
// out_stall, the next item is accepted and processed, and only its own
// hand-off waits for the register to empty.
// Reset clears the phase to zero and drops out_valid.
// ----------------------------------------------------------------------------
module phase_accumulator_sync_pm_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pasp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output pasp_pkg::out_item_t out_data
);

	pasp_pkg::cmd_t cmd;

	pasp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	pasp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// ===== src/pasp_checker.sv =====
// ----------------------------------------------------------------------------
// pasp_checker
// port-level checks of the phase accumulator, bound to the top level
// ----------------------------------------------------------------------------
`include "phase_accumulator_sync_pm_top_macros.svh"

module pasp_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input pasp_pkg::out_item_t out_data
);

	`PASP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output beat dropped under stall")
	`PASP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second beat taken while busy")
	`PASP_ASSERT_NOW(a_frac_zero, out_valid && !out_data.sync_out_valid, out_data.sync_out_frac == '0, "wrap position without wrap")
	`PASP_ASSERT_NOW(a_frac_range, out_valid, out_data.sync_out_frac <= (25'd1 << pasp_pkg::FRAC_BITS), "wrap position above one")

endmodule

bind phase_accumulator_sync_pm_top pasp_port_checker u_pasp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== dv/pasp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasp_checker
// Watches both channels of the phase accumulator, predicts each result beat
// from the accepted input beats and compares the two field by field.
// ----------------------------------------------------------------------------
module pasp_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  pasp_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  pasp_pkg::out_item_t out_data,
	output int                  fails,
	output int                  pending
);

	localparam int FB = pasp_pkg::FRAC_BITS;
	localparam int AB = pasp_pkg::ACC_BITS;
	localparam int PB = pasp_pkg::PROD_BITS;

	logic [AB-1:0]       acc_phase;
	pasp_pkg::out_item_t due_results[$];

	// one audio sample: sync load, single wrap, modulated output, advance
	function automatic pasp_pkg::out_item_t predict_sample(input pasp_pkg::in_item_t s);
		logic [AB-1:0]       ph;
		logic [PB-1:0]       prod;
		longint unsigned     num;
		pasp_pkg::out_item_t r;
		r = '0;
		ph = acc_phase;
		if (s.sync_valid) begin
			prod = s.sync_frac * s.phase_inc;
			ph = {1'b0, prod[PB-1:FB]};
		end
		if (ph[FB]) begin
			// phase stays below 2.0, so clearing the top bit subtracts one cycle
			ph[FB] = 1'b0;
			r.sync_out_valid = 1'b1;
			// zero increment or shrunk increment gives no intersample position
			if (s.phase_inc != '0 && ph < s.phase_inc) begin
				num = (longint'(s.phase_inc) - longint'(ph)) << FB;
				r.sync_out_frac = AB'(num / longint'(s.phase_inc));
			end
		end
		r.phase_out = ph[FB-1:0] + s.phase_shift;
		acc_phase = ph + s.phase_inc;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [AB-1:0] want,
			input logic [AB-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pasp_pkg::out_item_t want;
		if (!arst_n) begin
			acc_phase = '0;
			due_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("result beat with no prediction pending");
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("phase_out", {1'b0, want.phase_out},
						{1'b0, out_data.phase_out});
					check_field("sync_out_valid", AB'(want.sync_out_valid),
						AB'(out_data.sync_out_valid));
					check_field("sync_out_frac", want.sync_out_frac, out_data.sync_out_frac);
				end
			end
			if (in_valid && !in_stall)
				due_results.push_back(predict_sample(in_data));
		end
		pending = due_results.size();
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sample beats into the phase accumulator with hard sync: a directed
// run over wraps, syncs and increment corner cases, then random oscillator
// runs under several idle and stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	// longest quiet stretch: the output hold-off plus block time and stalls
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 340;
	localparam int FB          = pasp_pkg::FRAC_BITS;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	pasp_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	pasp_pkg::out_item_t out_data;
	int                  fails;
	int                  pending;

	int            idle_pct;
	int            stall_pct;
	int            hold_seq;
	int            hold_done;
	int            hold_left;
	int            quiet_cycles;
	logic [FB-1:0] osc_inc;

	int idle_tab[4]  = '{0, 80, 0, 8};
	int stall_tab[4] = '{0, 0, 80, 8};

	phase_accumulator_sync_pm_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	pasp_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.fails    (fails),
		.pending  (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// called right after a falling edge, returns right after one
	task automatic send_beat(input pasp_pkg::in_item_t s);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// oscillator-like runs: the increment holds for a while, then jumps
	function automatic pasp_pkg::in_item_t random_sample();
		pasp_pkg::in_item_t s;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 4))
				0: osc_inc = FB'($urandom_range(0, 15));
				1: osc_inc = FB'(24'hFFFFFF - $urandom_range(0, 15));
				2: osc_inc = FB'($urandom_range(0, 24'h00FFFF));
				default: osc_inc = FB'($urandom());
			endcase
		end
		s.phase_inc = osc_inc;
		if ($urandom_range(0, 15) == 0)
			s.phase_inc = FB'($urandom());
		s.sync_valid  = ($urandom_range(0, 5) == 0);
		s.sync_frac   = FB'($urandom());
		s.phase_shift = FB'($urandom());
		return s;
	endfunction

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_seq != hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = hold_seq;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_seq  = 0;
		osc_inc   = 24'h012345;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: full-scale steps, wraps, shrunk and zero increment, syncs
		send_beat(pasp_pkg::in_item_t'{24'h000000, 1'b0, 24'h000000, 24'h000000});
		send_beat(pasp_pkg::in_item_t'{24'hFFFFFF, 1'b0, 24'h000000, 24'hFFFFFF});
		send_beat(pasp_pkg::in_item_t'{24'hFFFFFF, 1'b0, 24'h000000, 24'h000000});
		send_beat(pasp_pkg::in_item_t'{24'hFFFFFF, 1'b0, 24'h000000, 24'hAAAAAA});
		// increment shrinks below the wrapped phase
		send_beat(pasp_pkg::in_item_t'{24'h000001, 1'b0, 24'h000000, 24'h555555});
		send_beat(pasp_pkg::in_item_t'{24'h000002, 1'b0, 24'h000000, 24'h000000});
		// wrap with a zero increment
		send_beat(pasp_pkg::in_item_t'{24'h000000, 1'b0, 24'h000000, 24'h123456});
		// wrap landing exactly on zero: position of a full sample
		send_beat(pasp_pkg::in_item_t'{24'h800000, 1'b0, 24'h000000, 24'h000000});
		send_beat(pasp_pkg::in_item_t'{24'h800000, 1'b0, 24'h000000, 24'h000000});
		send_beat(pasp_pkg::in_item_t'{24'h800000, 1'b0, 24'h000000, 24'h000000});
		// sync at full scale, then sync over a pending wrap
		send_beat(pasp_pkg::in_item_t'{24'hFFFFFF, 1'b1, 24'hFFFFFF, 24'h000000});
		send_beat(pasp_pkg::in_item_t'{24'hFFFFFF, 1'b1, 24'h000000, 24'hFFFFFF});
		send_beat(pasp_pkg::in_item_t'{24'h400000, 1'b1, 24'h800000, 24'h000000});
		send_beat(pasp_pkg::in_item_t'{24'h555555, 1'b1, 24'hAAAAAA, 24'h5A5A5A});
		send_beat(pasp_pkg::in_item_t'{24'hAAAAAA, 1'b0, 24'h555555, 24'hA5A5A5});
		send_beat(pasp_pkg::in_item_t'{24'hFFFFFF, 1'b0, 24'hFFFFFF, 24'hFFFFFF});
		send_beat(pasp_pkg::in_item_t'{24'h000001, 1'b1, 24'hFFFFFF, 24'h000001});
		send_beat(pasp_pkg::in_item_t'{24'h7FFFFF, 1'b0, 24'h000000, 24'h800000});
		send_beat(pasp_pkg::in_item_t'{24'h7FFFFF, 1'b0, 24'h000000, 24'h000000});
		send_beat(pasp_pkg::in_item_t'{24'h7FFFFF, 1'b0, 24'h000000, 24'h7FFFFF});
		send_beat(pasp_pkg::in_item_t'{24'hFFFFF0, 1'b0, 24'h000000, 24'h000000});

		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_tab[p];
			stall_pct = stall_tab[p];
			repeat (PHASE_ITEMS)
				send_beat(random_sample());
			// block fills up behind a stalled output while beats keep coming
			if (p == 0) begin
				hold_seq++;
				repeat (24)
					send_beat(random_sample());
			end
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
